FILE: rtl/acn_pkg.sv
package acn_pkg;

    localparam int DIV_W  = 32;  // operand width of the shared divider
    localparam int SUM_W  = 35;  // divisor sum width, never overflows
    localparam int CAND_W = 17;  // trial divisor, at most 65536
    localparam int SQ_W   = 34;  // running square of the trial divisor

    localparam logic [DIV_W-1:0] LIMIT_RESET = 32'd1000000;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DIV_W-1:0] remainder;
    } t_div_rsp;

endpackage

FILE: rtl/acn_div.sv
module acn_div (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  acn_pkg::t_div_req i_req,
    output acn_pkg::t_div_rsp o_rsp
);
    import acn_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_den;

    logic [DIV_W:0]   rem_sh;
    logic [DIV_W:0]   diff;
    logic             ge;
    logic [DIV_W-1:0] n_rem;
    logic [DIV_W-1:0] n_quo;

    // restoring division, one quotient bit per cycle
    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_W-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = !diff[DIV_W];
        n_rem  = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        n_quo  = {r_quo[DIV_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_cnt  <= CNT_W'(DIV_W - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

FILE: rtl/amicable_number_check.sv
// Channel   Direction  Handshake                 Payload
// -------   ---------  ------------------------  ------------------------------
// item in   input      start, accepted if !busy  i_number[31:0]
// result    output     o_done, one-cycle strobe  o_divisor_sum[34:0], o_is_amicable
// config    input      i_cfg_we, no wait         i_cfg_wdata[31:0] (search_limit)
//
// One item at a time. Each trial divisor passes a compare, a divider load,
// 32 bit-serial divide steps and a step that takes the quotient. A number
// n needs about sqrt(n) trial divisors, plus about sqrt(sum) when the
// partner sweep runs. Reset (i_rst_n low, synchronous) drops any item in
// flight and loads search_limit with 1000000. The result strobe cannot
// be stalled.
module amicable_number_check #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_number,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output logic        o_done,
    output logic [34:0] o_divisor_sum,
    output logic        o_is_amicable
);
    import acn_pkg::*;

    // only the low NUMBER_WIDTH bits of the item count; port is 32 bits
    localparam int NW = (NUMBER_WIDTH < DIV_W) ? NUMBER_WIDTH : DIV_W;
    localparam logic [DIV_W-1:0] NumMask = DIV_W'((65'(1) << NW) - 65'(1));

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_CHECK,
        S_WAIT,
        S_FINISH
    } t_state;

    t_state           r_state;
    logic [DIV_W-1:0] r_limit;
    logic [DIV_W-1:0] r_num;     // masked input item
    logic [DIV_W-1:0] r_target;  // value being swept: item, then its sum
    logic             r_pass;    // 0: item sweep, 1: partner sweep
    logic [CAND_W-1:0] r_cand;   // trial divisor d
    logic [SQ_W-1:0]  r_sq;      // d*d kept incrementally
    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] r_sum1;    // first-pass result
    logic             r_div_start;
    logic             r_done;
    logic [SUM_W-1:0] r_out_sum;
    logic             r_out_flag;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [SUM_W-1:0] cofac_add;
    logic             partner_ok;

    assign div_req.start    = r_div_start;
    assign div_req.dividend = r_target;
    assign div_req.divisor  = DIV_W'(r_cand);

    acn_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    // cofactor is added only when it differs from the divisor
    assign cofac_add = (div_rsp.quotient != DIV_W'(r_cand))
                     ? SUM_W'(div_rsp.quotient) : '0;

    // partner must lie strictly between the item and the limit
    assign partner_ok = (r_sum > SUM_W'(r_num)) && (r_sum < SUM_W'(r_limit));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RESET;
            r_div_start <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            r_done      <= 1'b0;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_num    <= i_number & NumMask;
                        r_target <= i_number & NumMask;
                        r_pass   <= 1'b0;
                        r_state  <= S_INIT;
                    end
                end
                S_INIT: begin
                    // sweep d upward from 2 while d*d <= target;
                    // same divisor set as a downward sweep from the root
                    r_cand  <= CAND_W'(2);
                    r_sq    <= SQ_W'(4);
                    r_sum   <= SUM_W'(1);
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_sq > SQ_W'(r_target)) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (div_rsp.done) begin
                        if (div_rsp.remainder == '0) begin
                            r_sum <= r_sum + SUM_W'(r_cand) + cofac_add;
                        end
                        // (d+1)^2 = d^2 + 2d + 1
                        r_sq    <= r_sq + SQ_W'({r_cand, 1'b1});
                        r_cand  <= r_cand + 1'b1;
                        r_state <= S_CHECK;
                    end
                end
                S_FINISH: begin
                    if (!r_pass) begin
                        r_sum1 <= r_sum;
                        if (partner_ok) begin
                            // sum < limit, so it fits the divider width
                            r_target <= r_sum[DIV_W-1:0];
                            r_pass   <= 1'b1;
                            r_state  <= S_INIT;
                        end else begin
                            r_out_sum  <= r_sum;
                            r_out_flag <= 1'b0;
                            r_done     <= 1'b1;
                            r_state    <= S_IDLE;
                        end
                    end else begin
                        r_out_sum  <= r_sum1;
                        r_out_flag <= (r_sum == SUM_W'(r_num));
                        r_done     <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = r_done;
    assign o_divisor_sum = r_out_sum;
    assign o_is_amicable = r_out_flag;

endmodule

FILE: rtl/acn_checker.sv
module acn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [34:0] o_divisor_sum,
    input logic        o_is_amicable
);

    // an accepted item always makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("item accepted but block not busy");

    // the result appears exactly as the block goes idle
    a_fell_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("block went idle without a result");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // an amicable flag needs a sum above one
    a_flag_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_is_amicable |-> o_divisor_sum > 35'd1)
        else $error("amicable flag with trivial divisor sum");

endmodule

bind amicable_number_check acn_checker u_acn_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_divisor_sum(o_divisor_sum),
    .o_is_amicable(o_is_amicable)
);

FILE: dv/amicable_number_check_tb.sv
module amicable_number_check_tb;
    import acn_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          NUMBER_WIDTH = 32;
    localparam logic [63:0] NUMBER_MASK  = (64'd1 << NUMBER_WIDTH) - 64'd1;
    localparam int          SETTLE_CYCLES = 8;   // idle margin after the last result
    localparam int          TAIL_CYCLES   = 50;  // watch for stray strobes at the end

    // one expected result: the sum and the pair flag
    typedef struct {
        logic [SUM_W-1:0] sum;
        logic             amic;
    } t_sum_entry;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_number;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic        o_done;
    logic [34:0] o_divisor_sum;
    logic        o_is_amicable;

    // expected results, oldest first
    t_sum_entry  pending_sums[$];
    // search_limit as the block should hold it
    logic [31:0] limit_model;
    int unsigned mismatches = 0;

    // sender pacing: bursts of items, random gaps in between
    int unsigned burst_left   = 0;
    bit          steady_run   = 1'b0;  // no gaps at all while set
    bit          holding_start = 1'b0; // start left high for the next item

    amicable_number_check #(
        .NUMBER_WIDTH(NUMBER_WIDTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_number     (i_number),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_divisor_sum(o_divisor_sum),
        .o_is_amicable(o_is_amicable)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Sum of proper divisors: start at 1, walk trial divisors from the floor
    // root down to 2, add each divisor and its cofactor when they differ.
    function automatic logic [63:0] proper_divisor_total(input logic [63:0] n);
        logic [63:0] total;
        logic [63:0] root;
        logic [63:0] trial;
        logic [63:0] d;
        total = 64'd1;
        // floor root, one bit at a time; operands stay below 2^35
        root = 64'd0;
        for (int b = 18; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n) begin
                root = trial;
            end
        end
        for (d = root; d > 64'd1; d = d - 64'd1) begin
            if (n % d == 64'd0) begin
                total = total + d;
                if (n / d != d) begin
                    total = total + n / d;
                end
            end
        end
        return total;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Offer one item, wait for it to be taken, record what it should yield,
    // then either keep start high for the next item or open a gap.
    task automatic send_item(input logic [31:0] n);
        logic [63:0] n64;
        logic [63:0] s;
        t_sum_entry  e;
        int unsigned gap;
        i_number <= n;
        start    <= 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        // taken at this edge
        n64    = {32'd0, n} & NUMBER_MASK;
        s      = proper_divisor_total(n64);
        e.sum  = s[SUM_W-1:0];
        // partner sweep only runs when the sum is above n and below the limit
        e.amic = (s > n64) && (s < {32'd0, limit_model})
                 && (proper_divisor_total(s) == n64);
        pending_sums.push_back(e);

        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 6);
            if (!steady_run) begin
                if ($urandom_range(0, 3) == 0) begin
                    gap = $urandom_range(20, 400);
                end else begin
                    gap = $urandom_range(1, 12);
                end
            end
        end
        burst_left--;
        if (gap != 0) begin
            start <= 1'b0;
            holding_start = 1'b0;
            repeat (gap) @(posedge i_clk);
        end else begin
            holding_start = 1'b1;
        end
    endtask

    // Drop start and hold off until every expected result is in.
    task automatic wait_results_drained();
        if (holding_start) begin
            start <= 1'b0;
            holding_start = 1'b0;
        end
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // search_limit only changes while the block is idle
    task automatic write_search_limit(input logic [31:0] value);
        wait_results_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        limit_model = value;
    endtask

    // Result side: the strobe cannot be held off, so every strobe is checked.
    always @(posedge i_clk) begin : check_results
        t_sum_entry want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (pending_sums.size() == 0) begin
                report_mismatch("result with no item pending", {29'd0, o_divisor_sum}, 64'd0);
            end else begin
                want = pending_sums.pop_front();
                if (o_divisor_sum !== want.sum) begin
                    report_mismatch("divisor_sum", {29'd0, o_divisor_sum}, {29'd0, want.sum});
                end
                if (o_is_amicable !== want.amic) begin
                    report_mismatch("is_amicable", {63'd0, o_is_amicable}, {63'd0, want.amic});
                end
            end
        end
    end

    // zero and one skip the sweep; squares hit the divisor equal to its cofactor
    task automatic test_small_values();
        send_item(32'd0);
        send_item(32'd1);
        send_item(32'd2);
        send_item(32'd3);
        send_item(32'd4);
        send_item(32'd25);
        send_item(32'd12);
        send_item(32'd945);   // odd abundant
    endtask

    // sum equals the number, so never flagged
    task automatic test_perfect_numbers();
        send_item(32'd6);
        send_item(32'd28);
        send_item(32'd496);
        send_item(32'd8128);
        send_item(32'd33550336);
    endtask

    // smaller members flag, larger members do not
    task automatic test_amicable_pairs();
        send_item(32'd220);
        send_item(32'd284);
        send_item(32'd1184);
        send_item(32'd1210);
        send_item(32'd12285);
    endtask

    // all ones: the longest sweep the block can see
    task automatic test_widest_number();
        send_item(32'hFFFF_FFFF);
    endtask

    // partner of 220 is 284: limit exactly at it, just above, zero, one, max
    task automatic test_limit_edges();
        write_search_limit(32'd284);
        send_item(32'd220);
        write_search_limit(32'd285);
        send_item(32'd220);
        write_search_limit(32'd0);
        send_item(32'd220);
        write_search_limit(32'd1);
        send_item(32'd220);
        write_search_limit(32'hFFFF_FFFF);
        send_item(32'd220);
        send_item(32'd284);
    endtask

    // Four phases under different limits. Most items are small so the sweep
    // stays short; a quarter are pair members to reach the partner sweep.
    task automatic test_random_traffic();
        logic [31:0] n;
        int unsigned kind;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_search_limit(LIMIT_RESET);
                1: write_search_limit(32'hFFFF_FFFF);
                2: write_search_limit($urandom_range(0, 70000));
                default: write_search_limit(32'd1);
            endcase
            steady_run = (phase == 1);
            for (int k = 0; k < 25; k++) begin
                // now and then let the block run dry before the next item
                if ($urandom_range(0, 15) == 0) begin
                    wait_results_drained();
                end
                kind = $urandom_range(0, 99);
                if (kind < 50) begin
                    n = $urandom_range(0, 4095);
                end else if (kind < 75) begin
                    case ($urandom_range(0, 19))
                        0: n = 32'd220;     1: n = 32'd284;
                        2: n = 32'd1184;    3: n = 32'd1210;
                        4: n = 32'd2620;    5: n = 32'd2924;
                        6: n = 32'd5020;    7: n = 32'd5564;
                        8: n = 32'd6232;    9: n = 32'd6368;
                        10: n = 32'd10744;  11: n = 32'd10856;
                        12: n = 32'd12285;  13: n = 32'd14595;
                        14: n = 32'd17296;  15: n = 32'd18416;
                        16: n = 32'd63020;  17: n = 32'd76084;
                        18: n = 32'd66928;  default: n = 32'd66992;
                    endcase
                end else if (kind < 85) begin
                    case ($urandom_range(0, 3))
                        0: n = 32'd6;
                        1: n = 32'd28;
                        2: n = 32'd496;
                        default: n = 32'd8128;
                    endcase
                end else begin
                    n = $urandom_range(0, 32'h000F_FFFF);
                end
                send_item(n);
            end
        end
    endtask

    initial begin : run_tests
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_number    <= 32'd0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 32'd0;
        limit_model = LIMIT_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_small_values();
        test_perfect_numbers();
        test_amicable_pairs();
        test_widest_number();
        test_limit_edges();
        test_random_traffic();

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("amicable_number_check test passed");
        end else begin
            $display("amicable_number_check test failed");
        end
        $finish;
    end

    // The all-ones item is the longest part of the expected run; this bound
    // leaves several times the whole run.
    initial begin : watchdog
        #400ms;
        $display("amicable_number_check test failed");
        $finish;
    end

endmodule
